[rtl/bfd_pkg.sv]
// Shared types and register map of the bypass flit buffer.
package bfd_pkg;

    typedef enum logic [1:0] {
        OP_ARRIVE = 2'd0,
        OP_TICK   = 2'd1,
        OP_SEND   = 2'd2,
        OP_DROP   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FEV_NONE     = 2'd0,
        FEV_FULL     = 2'd1,
        FEV_NOT_FULL = 2'd2
    } fev_t;

    // Register indexes; byte address is 4 * index.
    localparam logic [1:0] REG_AWAIT_REQUESTS = 2'd0;
    localparam logic [1:0] REG_SYNC_FIRST     = 2'd1;
    localparam logic [1:0] REG_MAX_LENGTH     = 2'd2;

    localparam int MAX_LENGTH_W = 5;
    localparam int TICK_W       = 32;

endpackage

[rtl/bypass_fifo_with_drop.sv]
// Bypass flit buffer with tail drop: one memory holds the queued flits and their arrival ticks.
//
// One request (arrival, tick, send request or drop request) is accepted every clock
// cycle while s_ready is high, and every request yields exactly one result: it passes
// the stage that follows the synchronous read of the queue memory, and then the
// output register where the wait time is computed. Queue pointers, the entry count,
// the tick counter and the bypass flag update at acceptance, so successive requests
// see each other's effect at once; a pop only follows writes made in earlier cycles.
// The result side may stall: the stage after the memory holds, and s_ready drops
// only when both it and the output register are full and m_ready is low.
// Configuration: await_requests at 0x0, sync_first at 0x4, max_length at 0x8,
// written by the user only while the buffer is idle; the block does not enforce this.
module bypass_fifo_with_drop #(
    parameter int DEPTH      = 16,
    parameter int FLIT_WIDTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [3:0]                   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    // requests
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_op,
    input  logic [FLIT_WIDTH-1:0]        s_flit_in,
    // results
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_sent_valid,
    output logic [FLIT_WIDTH-1:0]        m_flit_out,
    output logic [31:0]                  m_wait_cycles,
    output logic                         m_dropped,
    output logic [1:0]                   m_full_event,
    output logic [$clog2(DEPTH+1)-1:0]   m_queue_length
);

    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int LIM_W  = (CNT_W > bfd_pkg::MAX_LENGTH_W) ? CNT_W : bfd_pkg::MAX_LENGTH_W;
    localparam int TW     = bfd_pkg::TICK_W;
    localparam int ENTRY_W = FLIT_WIDTH + TW;

    // configuration registers
    logic                             await_reg;
    logic                             sync_first_reg;
    logic [bfd_pkg::MAX_LENGTH_W-1:0] max_length_reg;

    // control state
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [TW-1:0]    tick_reg, tick_next;
    logic             cycle_free_reg, cycle_free_next;

    // queue memory: {arrival tick, flit}
    logic [ENTRY_W-1:0] store_reg [DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;

    // stage after the memory read
    logic                  s1_valid_reg;
    logic                  s1_sent_reg, s1_sent_next;
    logic                  s1_from_mem_reg, s1_from_mem_next;
    logic [FLIT_WIDTH-1:0] s1_flit_reg, s1_flit_next;
    logic [TW-1:0]         s1_tick_reg;
    logic                  s1_drop_reg, s1_drop_next;
    bfd_pkg::fev_t         s1_fev_reg, s1_fev_next;
    logic [CNT_W-1:0]      s1_qlen_reg;

    // output register
    logic                  out_valid_reg;
    logic                  out_sent_reg;
    logic [FLIT_WIDTH-1:0] out_flit_reg;
    logic [TW-1:0]         out_wait_reg;
    logic                  out_drop_reg;
    bfd_pkg::fev_t         out_fev_reg;
    logic [CNT_W-1:0]      out_qlen_reg;

    logic             cfg_wr;
    logic             accept;
    logic             s1_adv;
    logic             wr_en;
    logic             rd_en;
    logic [LIM_W-1:0] limit;
    logic [LIM_W-1:0] count_ext;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        case (paddr[3:2])
            bfd_pkg::REG_AWAIT_REQUESTS: prdata[0] = await_reg;
            bfd_pkg::REG_SYNC_FIRST:     prdata[0] = sync_first_reg;
            bfd_pkg::REG_MAX_LENGTH:     prdata[bfd_pkg::MAX_LENGTH_W-1:0] = max_length_reg;
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            await_reg      <= 1'b0;
            sync_first_reg <= 1'b1;
            max_length_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bfd_pkg::REG_AWAIT_REQUESTS: await_reg <= pwdata[0];
                bfd_pkg::REG_SYNC_FIRST:     sync_first_reg <= pwdata[0];
                bfd_pkg::REG_MAX_LENGTH:
                    max_length_reg <= pwdata[bfd_pkg::MAX_LENGTH_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: the post-read stage moves when the output register is free or drained
    assign s1_adv  = !out_valid_reg || m_ready;
    assign s_ready = !s1_valid_reg || s1_adv;
    assign accept  = s_valid && s_ready;

    // effective limit: zero or beyond DEPTH means DEPTH
    always_comb begin
        if (max_length_reg == '0 || LIM_W'(max_length_reg) > LIM_W'(DEPTH)) begin
            limit = LIM_W'(DEPTH);
        end else begin
            limit = LIM_W'(max_length_reg);
        end
    end
    assign count_ext = LIM_W'(count_reg);

    always_comb begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        tick_next        = tick_reg;
        cycle_free_next  = cycle_free_reg;
        s1_sent_next     = 1'b0;
        s1_from_mem_next = 1'b0;
        s1_flit_next     = '0;
        s1_drop_next     = 1'b0;
        s1_fev_next      = bfd_pkg::FEV_NONE;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        case (bfd_pkg::op_t'(s_op))
            bfd_pkg::OP_ARRIVE: begin
                if (!await_reg && !sync_first_reg && cycle_free_reg) begin
                    s1_sent_next    = 1'b1;
                    s1_flit_next    = s_flit_in;
                    cycle_free_next = 1'b0;
                end else if (count_ext < limit) begin
                    wr_en      = 1'b1;
                    tail_next  = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    if (LIM_W'(count_next) == limit) begin
                        s1_fev_next = bfd_pkg::FEV_FULL;
                    end
                end else begin
                    s1_drop_next = 1'b1;
                end
            end
            bfd_pkg::OP_TICK: begin
                tick_next = tick_reg + 1'b1;
                if (count_reg == '0) begin
                    cycle_free_next = 1'b1;
                end else if (!await_reg) begin
                    rd_en            = 1'b1;
                    s1_sent_next     = 1'b1;
                    s1_from_mem_next = 1'b1;
                end
            end
            bfd_pkg::OP_SEND: begin
                if (await_reg && count_reg != '0) begin
                    rd_en            = 1'b1;
                    s1_sent_next     = 1'b1;
                    s1_from_mem_next = 1'b1;
                end
            end
            bfd_pkg::OP_DROP: begin
                if (await_reg && count_reg != '0) begin
                    rd_en = 1'b1;
                end
            end
            default: ;
        endcase
        // pop the head
        if (rd_en) begin
            head_next  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
            if (count_ext == limit) begin
                s1_fev_next = bfd_pkg::FEV_NOT_FULL;
            end
        end
    end

    // queue memory: one write port at the tail, one registered read port at the head
    always_ff @(posedge aclk) begin
        if (accept && wr_en) begin
            store_reg[tail_reg] <= {tick_reg, s_flit_in};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && rd_en) begin
            rd_data_reg <= store_reg[head_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            tick_reg       <= '0;
            cycle_free_reg <= 1'b1;
        end else if (accept) begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            tick_reg       <= tick_next;
            cycle_free_reg <= cycle_free_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sent_reg     <= s1_sent_next;
            s1_from_mem_reg <= s1_from_mem_next;
            s1_flit_reg     <= s1_flit_next;
            s1_tick_reg     <= tick_next;
            s1_drop_reg     <= s1_drop_next;
            s1_fev_reg      <= s1_fev_next;
            s1_qlen_reg     <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            out_sent_reg <= s1_sent_reg;
            out_drop_reg <= s1_drop_reg;
            out_fev_reg  <= s1_fev_reg;
            out_qlen_reg <= s1_qlen_reg;
            if (s1_from_mem_reg) begin
                out_flit_reg <= rd_data_reg[FLIT_WIDTH-1:0];
                out_wait_reg <= s1_tick_reg - rd_data_reg[ENTRY_W-1:FLIT_WIDTH];
            end else begin
                out_flit_reg <= s1_flit_reg;
                out_wait_reg <= '0;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_sent_valid   = out_sent_reg;
    assign m_flit_out     = out_flit_reg;
    assign m_wait_cycles  = out_wait_reg;
    assign m_dropped      = out_drop_reg;
    assign m_full_event   = out_fev_reg;
    assign m_queue_length = out_qlen_reg;

endmodule

[test/tb.sv]
// Self-checking testbench for the bypass flit buffer with tail drop.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int FLIT_WIDTH  = 64;
    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_LIMIT = 100;

    typedef struct {
        bfd_pkg::op_t op;
        logic [63:0]  flit;
    } flit_request_t;

    typedef struct {
        logic          sent;
        logic [63:0]   flit;
        logic [31:0]   wait_ticks;
        logic          dropped;
        bfd_pkg::fev_t fev;
        logic [4:0]    qlen;
    } buffer_result_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [3:0]            paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [1:0]            s_op      = bfd_pkg::OP_ARRIVE;
    logic [FLIT_WIDTH-1:0] s_flit_in = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic                  m_sent_valid;
    logic [FLIT_WIDTH-1:0] m_flit_out;
    logic [31:0]           m_wait_cycles;
    logic                  m_dropped;
    logic [1:0]            m_full_event;
    logic [4:0]            m_queue_length;

    bypass_fifo_with_drop #(
        .DEPTH     (DEPTH),
        .FLIT_WIDTH(FLIT_WIDTH)
    ) uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_flit_in     (s_flit_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sent_valid  (m_sent_valid),
        .m_flit_out    (m_flit_out),
        .m_wait_cycles (m_wait_cycles),
        .m_dropped     (m_dropped),
        .m_full_event  (m_full_event),
        .m_queue_length(m_queue_length)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Shadow of the buffer, at its state after reset
    logic [63:0] q_flits [DEPTH];
    logic [31:0] q_arrival [DEPTH];
    int          q_head      = 0;
    int          q_tail      = 0;
    int          q_count     = 0;
    logic [31:0] tick_count  = '0;
    logic        cycle_free  = 1'b1;
    logic        cfg_await   = 1'b0;
    logic        cfg_sync    = 1'b1;
    logic [4:0]  cfg_max_len = '0;

    flit_request_t  request_queue[$];
    buffer_result_t expected_results[$];
    buffer_result_t oldest_expected;
    int             send_idle_pct = 0;
    int             stall_pct     = 0;
    int             error_count   = 0;
    int             results_seen  = 0;
    int             cycle_count   = 0;

    function automatic int queue_limit();
        if (cfg_max_len == 0 || cfg_max_len > DEPTH) return DEPTH;
        return int'(cfg_max_len);
    endfunction

    function automatic bfd_pkg::fev_t pop_head(output logic [63:0] flit,
                                               output logic [31:0] arrived);
        flit    = q_flits[q_head];
        arrived = q_arrival[q_head];
        q_head  = (q_head + 1) % DEPTH;
        q_count--;
        return (q_count == queue_limit() - 1) ? bfd_pkg::FEV_NOT_FULL : bfd_pkg::FEV_NONE;
    endfunction

    function automatic buffer_result_t predict_buffer(bfd_pkg::op_t op, logic [63:0] flit);
        buffer_result_t r;
        logic [63:0]    popped;
        logic [31:0]    arrived;
        r.sent       = 1'b0;
        r.flit       = '0;
        r.wait_ticks = '0;
        r.dropped    = 1'b0;
        r.fev        = bfd_pkg::FEV_NONE;
        case (op)
            bfd_pkg::OP_ARRIVE: begin
                if (!cfg_await && !cfg_sync && cycle_free) begin
                    r.sent     = 1'b1;
                    r.flit     = flit;
                    cycle_free = 1'b0;
                end else if (q_count < queue_limit()) begin
                    q_flits[q_tail]   = flit;
                    q_arrival[q_tail] = tick_count;
                    q_tail            = (q_tail + 1) % DEPTH;
                    q_count++;
                    if (q_count == queue_limit()) r.fev = bfd_pkg::FEV_FULL;
                end else begin
                    r.dropped = 1'b1;
                end
            end
            bfd_pkg::OP_TICK: begin
                tick_count++;
                if (q_count == 0) begin
                    cycle_free = 1'b1;
                end else if (!cfg_await) begin
                    r.fev        = pop_head(popped, arrived);
                    r.sent       = 1'b1;
                    r.flit       = popped;
                    r.wait_ticks = tick_count - arrived;
                end
            end
            default: begin
                if (cfg_await && q_count != 0) begin
                    r.fev = pop_head(popped, arrived);
                    if (op == bfd_pkg::OP_SEND) begin
                        r.sent       = 1'b1;
                        r.flit       = popped;
                        r.wait_ticks = tick_count - arrived;
                    end
                end
            end
        endcase
        r.qlen = 5'(q_count);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: result %0d: %s got %0h expected %0h",
                     $realtime, results_seen, what, got, want);
    endtask

    // Driver: predict on acceptance, then present the next request or idle
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_op      <= bfd_pkg::OP_ARRIVE;
            s_flit_in <= '0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_buffer(bfd_pkg::op_t'(s_op), s_flit_in));
            if (!s_valid || s_ready) begin
                if (request_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid   <= 1'b1;
                    s_op      <= request_queue[0].op;
                    s_flit_in <= request_queue[0].flit;
                    void'(request_queue.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", m_flit_out, '0);
                end else begin
                    oldest_expected = expected_results.pop_front();
                    if (m_sent_valid !== oldest_expected.sent)
                        report_mismatch("sent_valid", 64'(m_sent_valid),
                                        64'(oldest_expected.sent));
                    if (m_flit_out !== oldest_expected.flit)
                        report_mismatch("flit_out", m_flit_out, oldest_expected.flit);
                    if (m_wait_cycles !== oldest_expected.wait_ticks)
                        report_mismatch("wait_cycles", 64'(m_wait_cycles),
                                        64'(oldest_expected.wait_ticks));
                    if (m_dropped !== oldest_expected.dropped)
                        report_mismatch("dropped", 64'(m_dropped),
                                        64'(oldest_expected.dropped));
                    if (m_full_event !== oldest_expected.fev)
                        report_mismatch("full_event", 64'(m_full_event),
                                        64'(oldest_expected.fev));
                    if (m_queue_length !== oldest_expected.qlen)
                        report_mismatch("queue_length", 64'(m_queue_length),
                                        64'(oldest_expected.qlen));
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("bypass_fifo_with_drop regression: fail");
            $finish;
        end
    end

    function automatic logic [63:0] random_flit();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic push_request(bfd_pkg::op_t op, logic [63:0] flit);
        flit_request_t req;
        req.op   = op;
        req.flit = flit;
        request_queue.push_back(req);
    endtask

    // Sample at the falling edge so driver updates of this cycle are settled
    task automatic wait_drained();
        do @(negedge aclk);
        while (request_queue.size() != 0 || s_valid || expected_results.size() != 0);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bfd_pkg::REG_AWAIT_REQUESTS: cfg_await   = value[0];
            bfd_pkg::REG_SYNC_FIRST:     cfg_sync    = value[0];
            bfd_pkg::REG_MAX_LENGTH:     cfg_max_len = value[4:0];
            default: ;
        endcase
    endtask

    task automatic write_setting(logic await_req, logic sync_first, logic [4:0] max_len);
        write_reg(bfd_pkg::REG_AWAIT_REQUESTS, 32'(await_req));
        write_reg(bfd_pkg::REG_SYNC_FIRST, 32'(sync_first));
        write_reg(bfd_pkg::REG_MAX_LENGTH, 32'(max_len));
    endtask

    // Mostly fill bursts and drain bursts, so the queue runs full and empty often
    task automatic add_random_requests(int count);
        int           added;
        int           kind;
        int           len;
        bfd_pkg::op_t op;
        added = 0;
        while (added < count) begin
            kind = $urandom_range(99);
            len  = $urandom_range(1, 20);
            for (int k = 0; k < len && added < count; k++) begin
                if (kind < 40)
                    op = bfd_pkg::OP_ARRIVE;
                else if (kind < 70)
                    op = !cfg_await ? bfd_pkg::OP_TICK
                         : ($urandom_range(3) == 0 ? bfd_pkg::OP_DROP
                            : ($urandom_range(7) == 0 ? bfd_pkg::OP_TICK : bfd_pkg::OP_SEND));
                else if (kind < 85)
                    op = (k % 2 == 0) ? bfd_pkg::OP_ARRIVE : bfd_pkg::OP_TICK;
                else
                    op = bfd_pkg::op_t'($urandom_range(3));
                push_request(op, random_flit());
                added++;
            end
        end
    endtask

    initial begin
        logic [4:0] max_choices [5];
        max_choices = '{5'd0, 5'd16, 5'd1, 5'd31, 5'd3};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 38;
        stall_pct     = 48;

        // Reset settings: queue everything, pop on ticks, requests ignored
        push_request(bfd_pkg::OP_ARRIVE, '1);
        push_request(bfd_pkg::OP_ARRIVE, '0);
        push_request(bfd_pkg::OP_TICK, '0);
        push_request(bfd_pkg::OP_TICK, '1);
        push_request(bfd_pkg::OP_TICK, '0);
        push_request(bfd_pkg::OP_SEND, '0);
        push_request(bfd_pkg::OP_DROP, '0);
        wait_drained();

        // Bypass enabled: first arrival leaves at once, the next one queues
        write_reg(bfd_pkg::REG_SYNC_FIRST, 32'd0);
        push_request(bfd_pkg::OP_ARRIVE, 64'h8000_0000_0000_0001);
        push_request(bfd_pkg::OP_ARRIVE, 64'h5555_aaaa_5555_aaaa);
        push_request(bfd_pkg::OP_TICK, '0);
        push_request(bfd_pkg::OP_TICK, '0);
        push_request(bfd_pkg::OP_ARRIVE, 64'haaaa_5555_aaaa_5555);
        wait_drained();

        // Pop on requests with a limit of one: drop at the limit, ticks only count
        write_reg(bfd_pkg::REG_MAX_LENGTH, 32'd1);
        write_reg(bfd_pkg::REG_AWAIT_REQUESTS, 32'd1);
        push_request(bfd_pkg::OP_ARRIVE, 64'h0123_4567_89ab_cdef);
        push_request(bfd_pkg::OP_ARRIVE, 64'hfedc_ba98_7654_3210);
        push_request(bfd_pkg::OP_TICK, '0);
        push_request(bfd_pkg::OP_SEND, '0);
        push_request(bfd_pkg::OP_DROP, '0);
        push_request(bfd_pkg::OP_ARRIVE, 64'h0f0f_0f0f_0f0f_0f0f);
        push_request(bfd_pkg::OP_DROP, '0);
        wait_drained();

        // Lower the limit below the current count
        write_setting(1'b0, 1'b1, 5'd2);
        push_request(bfd_pkg::OP_ARRIVE, 64'h1111_2222_3333_4444);
        push_request(bfd_pkg::OP_ARRIVE, 64'h9999_8888_7777_6666);
        wait_drained();
        write_reg(bfd_pkg::REG_MAX_LENGTH, 32'd1);
        push_request(bfd_pkg::OP_ARRIVE, 64'hdead_beef_dead_beef);
        push_request(bfd_pkg::OP_TICK, '0);
        push_request(bfd_pkg::OP_TICK, '0);
        wait_drained();

        for (int mode = 0; mode < 3; mode++) begin
            send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 48 : 0;
            stall_pct     = (mode == 0) ? 48 : (mode == 1) ? 38 : 0;
            for (int ph = 0; ph < 5; ph++) begin
                write_setting(1'((ph + mode) % 2), 1'(ph / 2 % 2),
                              (ph == 4) ? 5'($urandom_range(31)) : max_choices[(ph + mode) % 5]);
                add_random_requests(65);
                // hold off until the buffer has answered everything
                wait_drained();
                add_random_requests(65);
                wait_drained();
            end
        end

        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("bypass_fifo_with_drop regression: pass");
        else
            $display("bypass_fifo_with_drop regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/bfd_pkg.sv
rtl/bypass_fifo_with_drop.sv
test/tb.sv
